>>> hw/rtl/lcfrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfrs_pkg
// Shared types and constants for the led cube frame receiver and scanner.
// ----------------------------------------------------------------------------
package lcfrs_pkg;

  // character codes
  localparam logic [7:0] END_MARK   = 8'h78;
  localparam logic [7:0] DIGIT_ONE  = 8'h31;
  localparam logic [7:0] DIGIT_FOUR = 8'h34;

  // frame geometry
  localparam int unsigned FRAME_CHARS = 16;
  localparam logic [3:0]  LAST_CHAR   = 4'(FRAME_CHARS - 1);
  localparam logic [1:0]  LAST_LAYER  = 2'd3;

  // configuration register reset values
  localparam logic [7:0]  DWELL_RESET   = 8'd3;
  localparam logic [15:0] PATTERN_RESET = 16'd60;

  // configuration register indexes (address bit 2)
  localparam logic REG_DWELL   = 1'b0;
  localparam logic REG_PATTERN = 1'b1;

  // input operation codes
  localparam logic OPER_BYTE = 1'b0;
  localparam logic OPER_TICK = 1'b1;

  // classified work passed from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FRAME = 2'd2
  } lcfrs_op_t;

  typedef struct packed {
    lcfrs_op_t   op;
    logic [63:0] frame_map;
  } lcfrs_work_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } lcfrs_in_t;

  typedef struct packed {
    logic [3:0]  layer_enable;
    logic [15:0] led_columns;
    logic        showing;
  } lcfrs_out_t;

endpackage

>>> hw/rtl/led_cube_frame_receiver_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_cube_frame_receiver_scanner_core
// Receives frame characters and millisecond ticks, scans a 4x4x4 led cube
// one layer at a time and returns the lit layer for every item.
// ----------------------------------------------------------------------------
// An accepted item passes through the work queue to the display side, which
// registers its result; one item is accepted per cycle while in_stall is low.
// A two-entry work queue lets the receiver keep accepting while the result
// register is stalled; in_stall rises only when that queue is full.
// Reset (rst_n, synchronous, active low) clears the frame, scan state and
// queue and loads dwell 3 and pattern budget 60.
module led_cube_frame_receiver_scanner_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lcfrs_pkg::lcfrs_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcfrs_pkg::lcfrs_out_t out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0]  dwell_r, dwell_nxt;
  logic [15:0] pattern_r, pattern_nxt;
  logic        cfg_write;
  logic        in_accept;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  lcfrs_pkg::lcfrs_work_t work;
  lcfrs_pkg::lcfrs_work_t q_rdata;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    dwell_nxt   = dwell_r;
    pattern_nxt = pattern_r;
    cfg_prdata  = '0;
    unique case (cfg_paddr[2])
      lcfrs_pkg::REG_DWELL: begin
        cfg_prdata = {24'b0, dwell_r};
        if (cfg_write) dwell_nxt = cfg_pwdata[7:0];
      end
      lcfrs_pkg::REG_PATTERN: begin
        cfg_prdata = {16'b0, pattern_r};
        if (cfg_write) pattern_nxt = cfg_pwdata[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r   <= lcfrs_pkg::DWELL_RESET;
      pattern_r <= lcfrs_pkg::PATTERN_RESET;
    end else begin
      dwell_r   <= dwell_nxt;
      pattern_r <= pattern_nxt;
    end
  end

  // input transfer
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  lcfrs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .work   (work)
  );

  lcfrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .wdata     (work),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  lcfrs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dwell_cfg   (dwell_r),
    .pattern_cfg (pattern_r),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> hw/rtl/lcfrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfrs_front
// Receiver side: assembles 16 characters into a frame map and classifies
// each accepted item into tick, completed frame or nothing.
// ----------------------------------------------------------------------------
module lcfrs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  lcfrs_pkg::lcfrs_in_t  item,
  output lcfrs_pkg::lcfrs_work_t work
);

  logic [63:0] staging_r, staging_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        skipping_r, skipping_nxt;
  logic [63:0] lit_map;
  logic [7:0]  digit;
  logic        is_digit;

  // digit decode and bit position {char index, row}
  assign is_digit = (item.byte_value >= lcfrs_pkg::DIGIT_ONE) &&
                    (item.byte_value <= lcfrs_pkg::DIGIT_FOUR);
  assign digit    = item.byte_value - lcfrs_pkg::DIGIT_ONE;

  always_comb begin
    lit_map = staging_r;
    if (is_digit) begin
      lit_map[{count_r, digit[1:0]}] = 1'b1;
    end
  end

  // classification and receiver state update
  always_comb begin
    staging_nxt    = staging_r;
    count_nxt      = count_r;
    skipping_nxt   = skipping_r;
    work.op        = lcfrs_pkg::OP_NONE;
    work.frame_map = lit_map;
    if (item.operation == lcfrs_pkg::OPER_TICK) begin
      work.op = lcfrs_pkg::OP_TICK;
    end else if (skipping_r) begin
      if (item.byte_value == lcfrs_pkg::END_MARK) begin
        skipping_nxt = 1'b0;
      end
    end else if (count_r == lcfrs_pkg::LAST_CHAR) begin
      work.op      = lcfrs_pkg::OP_FRAME;
      count_nxt    = '0;
      skipping_nxt = 1'b1;
      staging_nxt  = '0;
    end else begin
      count_nxt   = count_r + 4'd1;
      staging_nxt = lit_map;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staging_r  <= '0;
      count_r    <= '0;
      skipping_r <= 1'b0;
    end else if (accept) begin
      staging_r  <= staging_nxt;
      count_r    <= count_nxt;
      skipping_r <= skipping_nxt;
    end
  end

endmodule

>>> hw/rtl/lcfrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfrs_queue
// Two-entry queue between the receiver front and the display back.
// ----------------------------------------------------------------------------
module lcfrs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lcfrs_pkg::lcfrs_work_t wdata,
  input  logic                   pop,
  output lcfrs_pkg::lcfrs_work_t rdata,
  output logic                   full,
  output logic                   not_empty
);

  lcfrs_pkg::lcfrs_work_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign rdata     = entry_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> hw/rtl/lcfrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfrs_back
// Display side: runs the layer scan, holds shown and pending frames and
// registers one result for every queued item.
// ----------------------------------------------------------------------------
module lcfrs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             dwell_cfg,
  input  logic [15:0]            pattern_cfg,
  input  logic                   q_not_empty,
  input  lcfrs_pkg::lcfrs_work_t q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcfrs_pkg::lcfrs_out_t  out_data
);

  logic [63:0] shown_r, shown_nxt;
  logic [63:0] pending_map_r, pending_map_nxt;
  logic        pending_r, pending_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  layer_r, layer_nxt;
  logic [7:0]  dwell_r, dwell_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        out_valid_r, out_valid_nxt;
  lcfrs_pkg::lcfrs_out_t out_r, out_nxt;

  logic [7:0]  dlen;
  logic [9:0]  pass_len;
  logic [8:0]  dwell_inc;
  logic        start_req;
  logic [63:0] start_map;

  // take the next item when the result register is free or being drained
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dlen     = (dwell_cfg == 8'd0) ? 8'd1 : dwell_cfg;
  assign pass_len = {dlen, 2'b00};

  // display state update
  always_comb begin
    shown_nxt       = shown_r;
    pending_map_nxt = pending_map_r;
    pending_nxt     = pending_r;
    active_nxt      = active_r;
    layer_nxt       = layer_r;
    dwell_nxt       = dwell_r;
    elapsed_nxt     = elapsed_r;
    dwell_inc       = {1'b0, dwell_r} + 9'd1;
    start_req       = 1'b0;
    start_map       = q_rdata.frame_map;
    if (q_pop) begin
      case (q_rdata.op)
        lcfrs_pkg::OP_TICK: begin
          if (active_r) begin
            if (elapsed_r != 16'hFFFF) begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
            if (dwell_inc < {1'b0, dlen}) begin
              dwell_nxt = dwell_inc[7:0];
            end else begin
              dwell_nxt = '0;
              if (layer_r != lcfrs_pkg::LAST_LAYER) begin
                layer_nxt = layer_r + 2'd1;
              end else begin
                layer_nxt = '0;
                // end of pass: stop when another pass no longer fits
                if (({1'b0, elapsed_nxt} + {7'b0, pass_len}) > {1'b0, pattern_cfg}) begin
                  active_nxt  = 1'b0;
                  elapsed_nxt = '0;
                  if (pending_r) begin
                    pending_nxt = 1'b0;
                    start_req   = 1'b1;
                    start_map   = pending_map_r;
                  end
                end
              end
            end
          end
        end
        lcfrs_pkg::OP_FRAME: begin
          if (active_r) begin
            pending_map_nxt = q_rdata.frame_map;
            pending_nxt     = 1'b1;
          end else begin
            start_req = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // load a frame; it stays dark when no whole pass fits the budget
    if (start_req) begin
      layer_nxt   = '0;
      dwell_nxt   = '0;
      elapsed_nxt = '0;
      if ({6'b0, pass_len} <= pattern_cfg) begin
        shown_nxt  = start_map;
        active_nxt = 1'b1;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  // result for the item taken this cycle
  always_comb begin
    out_nxt = '0;
    if (active_nxt) begin
      out_nxt.layer_enable = 4'b0001 << layer_nxt;
      out_nxt.led_columns  = shown_nxt[{layer_nxt, 4'b0000} +: 16];
      out_nxt.showing      = 1'b1;
    end
    out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r       <= '0;
      pending_map_r <= '0;
      pending_r     <= 1'b0;
      active_r      <= 1'b0;
      layer_r       <= '0;
      dwell_r       <= '0;
      elapsed_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      shown_r       <= shown_nxt;
      pending_map_r <= pending_map_nxt;
      pending_r     <= pending_nxt;
      active_r      <= active_nxt;
      layer_r       <= layer_nxt;
      dwell_r       <= dwell_nxt;
      elapsed_r     <= elapsed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  a_lit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.showing) |-> $onehot(out_r.layer_enable))
    else $error("lit result without a single layer");

  a_dark_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.showing) |->
      (out_r.layer_enable == 4'd0 && out_r.led_columns == 16'd0))
    else $error("dark result drives leds");

  a_pending_only_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> active_r)
    else $error("frame pending while display idle");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the led cube frame receiver and layer scanner:
// drives bytes and ticks, rewrites dwell and budget over APB between phases,
// and checks every result against the directed table or the scan predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int LONG_HOLD    = 100;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 85;
  localparam int RANDOM_PHASE = 7;
  localparam int HOLD_PHASE   = 4;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                  typed;
    lcfrs_pkg::lcfrs_in_t  item;
    lcfrs_pkg::lcfrs_out_t result;
  } stim_row_t;

  localparam lcfrs_pkg::lcfrs_out_t DARK =
    '{layer_enable: 4'h0, led_columns: 16'h0000, showing: 1'b0};
  localparam lcfrs_pkg::lcfrs_out_t ANY  =
    '{layer_enable: 4'h0, led_columns: 16'h0000, showing: 1'b0};

  // directed rows at reset settings: frame of 16 chars, skip, 'x', layer steps
  localparam int NUM_ROWS = 24;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b1, '{lcfrs_pkg::OPER_TICK, 8'h00}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'hFF}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h00}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h31}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h32}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h33}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h34}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h30}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h35}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h78}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h34}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h33}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h32}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h31}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h34}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h7F}, DARK},
    '{1'b1, '{lcfrs_pkg::OPER_BYTE, 8'h31}, '{4'b0001, 16'h2100, 1'b1}},
    '{1'b0, '{lcfrs_pkg::OPER_BYTE, 8'h32}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_BYTE, 8'h78}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_TICK, 8'hFF}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_TICK, 8'h00}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_TICK, 8'h5A}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_BYTE, 8'hFE}, ANY},
    '{1'b0, '{lcfrs_pkg::OPER_TICK, 8'hA5}, ANY}
  };

  // per-phase settings: exact pass, too small, zero dwell, maxima, defaults
  localparam logic [7:0]  PHASE_DWELL   [NUM_PHASES] = '{
    8'd1, 8'd1, 8'd0, 8'd0, 8'd2, 8'd255, 8'd255, 8'd0, 8'd3, 8'd1};
  localparam logic [15:0] PHASE_PATTERN [NUM_PHASES] = '{
    16'd4, 16'd3, 16'd4, 16'd0, 16'd40, 16'd65535, 16'd1019, 16'd0, 16'd60, 16'd65535};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  lcfrs_pkg::lcfrs_in_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lcfrs_pkg::lcfrs_out_t out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [2:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // predictor copy of the registers and scan state
  logic [7:0]  dwell_reg;
  logic [15:0] budget_reg;
  logic [63:0] build_map;
  logic [63:0] lit_map;
  logic [63:0] queued_map;
  logic        queued_valid;
  logic [4:0]  char_idx;
  logic        drop_to_mark;
  logic        scanning;
  logic [1:0]  scan_layer;
  logic [7:0]  dwell_cnt;
  logic [15:0] ticks_shown;

  lcfrs_pkg::lcfrs_out_t lit_layer_q [$];
  lcfrs_pkg::lcfrs_out_t lit_want;
  int          err_count = 0;
  int          idle_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          stall_pct = 0;

  led_cube_frame_receiver_scanner_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // scan predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned dwell_span();
    return (dwell_reg == 8'd0) ? 1 : int'(dwell_reg);
  endfunction

  task automatic scan_clear();
    dwell_reg    = lcfrs_pkg::DWELL_RESET;
    budget_reg   = lcfrs_pkg::PATTERN_RESET;
    build_map    = '0;
    lit_map      = '0;
    queued_map   = '0;
    queued_valid = 1'b0;
    char_idx     = '0;
    drop_to_mark = 1'b0;
    scanning     = 1'b0;
    scan_layer   = '0;
    dwell_cnt    = '0;
    ticks_shown  = '0;
  endtask

  // start a display, or stay dark when no whole pass fits in the budget
  task automatic show_map(input logic [63:0] map);
    scan_layer  = '0;
    dwell_cnt   = '0;
    ticks_shown = '0;
    if (4 * dwell_span() <= int'(budget_reg)) begin
      lit_map  = map;
      scanning = 1'b1;
    end else begin
      scanning = 1'b0;
    end
  endtask

  task automatic end_show();
    scanning    = 1'b0;
    scan_layer  = '0;
    dwell_cnt   = '0;
    ticks_shown = '0;
    if (queued_valid) begin
      queued_valid = 1'b0;
      show_map(queued_map);
    end
  endtask

  task automatic scan_tick();
    if (!scanning) return;
    if (ticks_shown != 16'hFFFF) ticks_shown = ticks_shown + 16'd1;
    dwell_cnt = dwell_cnt + 8'd1;
    if (int'(dwell_cnt) < dwell_span()) return;
    dwell_cnt = '0;
    if (scan_layer < lcfrs_pkg::LAST_LAYER) begin
      scan_layer = scan_layer + 2'd1;
      return;
    end
    scan_layer = '0;
    if (int'(ticks_shown) + 4 * dwell_span() > int'(budget_reg)) end_show();
  endtask

  task automatic take_char(input logic [7:0] c);
    int bit_pos;
    if (drop_to_mark) begin
      if (c == lcfrs_pkg::END_MARK) drop_to_mark = 1'b0;
      return;
    end
    if (c >= lcfrs_pkg::DIGIT_ONE && c <= lcfrs_pkg::DIGIT_FOUR) begin
      bit_pos = int'(char_idx[3:2]) * 16 + int'(char_idx[1:0]) * 4 +
                int'(c - lcfrs_pkg::DIGIT_ONE);
      build_map[bit_pos] = 1'b1;
    end
    char_idx = char_idx + 5'd1;
    if (int'(char_idx) >= lcfrs_pkg::FRAME_CHARS) begin
      char_idx     = '0;
      drop_to_mark = 1'b1;
      if (scanning) begin
        queued_map   = build_map;
        queued_valid = 1'b1;
      end else begin
        show_map(build_map);
      end
      build_map = '0;
    end
  endtask

  task automatic predict_lit_layer(input lcfrs_pkg::lcfrs_in_t item,
                                   output lcfrs_pkg::lcfrs_out_t res);
    if (item.operation == lcfrs_pkg::OPER_TICK) scan_tick();
    else take_char(item.byte_value);
    if (scanning) begin
      res.layer_enable = 4'b0001 << scan_layer;
      res.led_columns  = lit_map[int'(scan_layer) * 16 +: 16];
      res.showing      = 1'b1;
    end else begin
      res = DARK;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  task automatic send_item(input lcfrs_pkg::lcfrs_in_t item, input logic typed,
                           input lcfrs_pkg::lcfrs_out_t typed_res);
    lcfrs_pkg::lcfrs_out_t res;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_lit_layer(item, res);
    lit_layer_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lit_layer_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_cube_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == lcfrs_pkg::REG_DWELL) dwell_reg = value[7:0];
    else budget_reg = value[15:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = (idx == lcfrs_pkg::REG_DWELL) ? {24'h0, dwell_reg} : {16'h0, budget_reg};
    if (cfg_prdata !== want) begin
      $error("cfg_prdata at %0h: expected %h got %h", {idx, 2'b00}, want, cfg_prdata);
      err_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // mostly digits and end marks with random noise; tick share set per phase
  function automatic lcfrs_pkg::lcfrs_in_t random_item(input int tick_pct);
    lcfrs_pkg::lcfrs_in_t item;
    int pick;
    item.byte_value = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < tick_pct) begin
      item.operation = lcfrs_pkg::OPER_TICK;
    end else begin
      item.operation = lcfrs_pkg::OPER_BYTE;
      pick = $urandom_range(0, 99);
      if (pick < 70) item.byte_value = lcfrs_pkg::DIGIT_ONE + 8'($urandom_range(0, 3));
      else if (pick < 80) item.byte_value = lcfrs_pkg::END_MARK;
    end
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // result receiver: stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left = mode_left - 1;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lit_layer_q.size() == 0) begin
        $error("unexpected transfer on out: %h", out_data);
        err_count++;
      end else begin
        lit_want = lit_layer_q.pop_front();
        if (out_data.layer_enable !== lit_want.layer_enable) begin
          $error("layer_enable: expected %h got %h", lit_want.layer_enable,
                 out_data.layer_enable);
          err_count++;
        end
        if (out_data.led_columns !== lit_want.led_columns) begin
          $error("led_columns: expected %h got %h", lit_want.led_columns,
                 out_data.led_columns);
          err_count++;
        end
        if (out_data.showing !== lit_want.showing) begin
          $error("showing: expected %h got %h", lit_want.showing, out_data.showing);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          burst_left;
    int          tick_pct;
    logic [7:0]  dwell_val;
    logic [15:0] budget_val;

    scan_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++)
      send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].result);

    // random phases, settings changed only with nothing in flight
    burst_left = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      dwell_val  = PHASE_DWELL[p];
      budget_val = PHASE_PATTERN[p];
      if (p == RANDOM_PHASE) begin
        dwell_val  = 8'($urandom_range(0, 6));
        budget_val = 16'($urandom_range(0, 120));
      end
      write_cube_reg(lcfrs_pkg::REG_DWELL, {24'h0, dwell_val});
      write_cube_reg(lcfrs_pkg::REG_PATTERN, {16'h0, budget_val});
      tick_pct = $urandom_range(25, 65);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p % 2 == 0) drain_results();
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
          burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        send_item(random_item(tick_pct), 1'b0, ANY);
      end
    end

    // wind down
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lit_layer_q.size() != 0) begin
      $error("results still expected at end: %0d", lit_layer_q.size());
      err_count++;
    end
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
